// File: hdl/rccm_pkg.sv
package rccm_pkg;

    localparam int MAX_IMAGES_DEF   = 8;
    localparam int MAX_FEATURES_DEF = 1024;

    localparam int OP_W       = 2;
    localparam int IMG_FW     = 3;
    localparam int FEAT_FW    = 10;
    localparam int DIST_W     = 16;
    localparam int RATIO_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd486;
    localparam logic [DIST_W-1:0]  EMPTY_RESET = 16'd16000;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO = 2'd0,
        CFG_EMPTY = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic               valid;
        logic [FEAT_FW-1:0] feat;
        logic [DIST_W-1:0]  best;
        logic [DIST_W-1:0]  second;
    } entry_t;

endpackage

// File: hdl/rccm_if.sv
interface rccm_in_if;
    logic                        valid;
    logic                        ready;
    logic [rccm_pkg::OP_W-1:0]    op;
    logic [rccm_pkg::IMG_FW-1:0]  query_image;
    logic [rccm_pkg::IMG_FW-1:0]  train_image;
    logic [rccm_pkg::FEAT_FW-1:0] query_feature;
    logic [rccm_pkg::FEAT_FW-1:0] train_feature;
    logic [rccm_pkg::DIST_W-1:0]  distance;

    modport source (
        output valid, op, query_image, train_image, query_feature, train_feature, distance,
        input  ready
    );
    modport sink (
        input  valid, op, query_image, train_image, query_feature, train_feature, distance,
        output ready
    );
endinterface

interface rccm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        match_valid;
    logic [rccm_pkg::FEAT_FW-1:0] matched_feature;
    logic [rccm_pkg::DIST_W-1:0]  match_distance;

    modport source (
        output valid, match_valid, matched_feature, match_distance,
        input  ready
    );
    modport sink (
        input  valid, match_valid, matched_feature, match_distance,
        output ready
    );
endinterface

// File: hdl/rccm_table_mem.sv
module rccm_table_mem #(
    parameter int ADDR_W = 16
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  rccm_pkg::entry_t      wdata,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     raddr,
    output rccm_pkg::entry_t      rdata
);
    import rccm_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ratio_cross_check_match_refiner_top.sv
// Insert and clear items are handled as one table read, then the write-back.
// A query item reaches its result through the entry read, the reverse entry read,
// then the output register; the table has a single read port, so the two reads take turns.
// A result waiting in the output register stalls only the next query at its last step.
// After reset the table is swept one entry a cycle, all 2**(2*clog2(MAX_IMAGES)+clog2(MAX_FEATURES))
// entries (65536 at the defaults), and no item is accepted until the sweep ends.
module ratio_cross_check_match_refiner_top #(
    parameter int MAX_IMAGES   = rccm_pkg::MAX_IMAGES_DEF,
    parameter int MAX_FEATURES = rccm_pkg::MAX_FEATURES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rccm_in_if.sink                          item_in,
    rccm_out_if.source                       result_out,
    input  logic                             cfg_we,
    input  logic [rccm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rccm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rccm_pkg::*;

    localparam int IMG_W  = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
    localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int ADDR_W = 2 * IMG_W + FEAT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_REVERSE
    } state_t;

    function automatic logic ratio_pass(entry_t e, logic [RATIO_W-1:0] thr);
        logic [RATIO_W+DIST_W-1:0] rhs;
        rhs = thr * e.second;
        return e.valid && ({2'b00, e.best, 8'h00} < rhs);
    endfunction

    state_t                 state_reg, state_next;
    logic                   clearing_reg, clearing_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [IMG_FW-1:0]      qi_reg, qi_next;
    logic [IMG_FW-1:0]      ti_reg, ti_next;
    logic [FEAT_FW-1:0]     qf_reg, qf_next;
    logic [FEAT_FW-1:0]     tf_reg, tf_next;
    logic [DIST_W-1:0]      dist_reg, dist_next;
    logic                   ok_reg, ok_next;
    logic                   need_rev_reg, need_rev_next;
    logic [FEAT_FW-1:0]     res_feat_reg, res_feat_next;
    logic [DIST_W-1:0]      res_dist_reg, res_dist_next;
    logic [RATIO_W-1:0]     ratio_reg, ratio_next;
    logic [DIST_W-1:0]      empty_reg, empty_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_match_reg, out_match_next;
    logic [FEAT_FW-1:0]     out_feat_reg, out_feat_next;
    logic [DIST_W-1:0]      out_dist_reg, out_dist_next;

    logic                   accept;
    logic                   in_ok;
    logic [ADDR_W-1:0]      in_addr;
    logic [ADDR_W-1:0]      item_addr;
    logic [ADDR_W-1:0]      rev_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    entry_t                 cur;
    entry_t                 updated;
    entry_t                 emptied;
    entry_t                 swept;
    logic                   out_free;

    rccm_table_mem #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (cur)
    );

    assign item_in.ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign accept        = item_in.valid && item_in.ready;

    assign in_ok = (32'(item_in.query_image) < MAX_IMAGES)
                && (32'(item_in.train_image) < MAX_IMAGES)
                && (32'(item_in.query_feature) < MAX_FEATURES);

    assign in_addr   = {IMG_W'(item_in.query_image), IMG_W'(item_in.train_image),
                        FEAT_W'(item_in.query_feature)};
    assign item_addr = {IMG_W'(qi_reg), IMG_W'(ti_reg), FEAT_W'(qf_reg)};
    assign rev_addr  = {IMG_W'(ti_reg), IMG_W'(qi_reg), FEAT_W'(cur.feat)};

    assign out_free = !out_valid_reg || result_out.ready;

    always_comb
    begin
        updated = cur;
        if (dist_reg < cur.best)
        begin
            updated.second = cur.best;
            updated.best   = dist_reg;
            updated.feat   = tf_reg;
            updated.valid  = 1'b1;
        end
        else if (dist_reg < cur.second)
        begin
            updated.second = dist_reg;
        end
    end

    always_comb
    begin
        emptied.valid  = 1'b0;
        emptied.feat   = '0;
        emptied.best   = empty_reg;
        emptied.second = empty_reg;
        swept.valid    = 1'b0;
        swept.feat     = '0;
        swept.best     = EMPTY_RESET;
        swept.second   = EMPTY_RESET;
    end

    always_comb
    begin
        state_next     = state_reg;
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        qi_next        = qi_reg;
        ti_next        = ti_reg;
        qf_next        = qf_reg;
        tf_next        = tf_reg;
        dist_next      = dist_reg;
        ok_next        = ok_reg;
        need_rev_next  = need_rev_reg;
        res_feat_next  = res_feat_reg;
        res_dist_next  = res_dist_reg;
        ratio_next     = ratio_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        out_match_next = out_match_reg;
        out_feat_next  = out_feat_reg;
        out_dist_next  = out_dist_reg;
        mem_we         = 1'b0;
        mem_waddr      = item_addr;
        mem_wdata      = updated;
        mem_re         = 1'b0;
        mem_raddr      = in_addr;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RATIO: ratio_next = cfg_data[RATIO_W-1:0];
                CFG_EMPTY: empty_next = cfg_data[DIST_W-1:0];
                default:   ;
            endcase
        end

        if (out_valid_reg && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (clearing_reg)
        begin
            mem_we       = 1'b1;
            mem_waddr    = clr_cnt_reg;
            mem_wdata    = swept;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = item_in.op;
                    qi_next    = item_in.query_image;
                    ti_next    = item_in.train_image;
                    qf_next    = item_in.query_feature;
                    tf_next    = item_in.train_feature;
                    dist_next  = item_in.distance;
                    ok_next    = in_ok;
                    mem_re     = 1'b1;
                    state_next = ST_ENTRY;
                end
            end
            ST_ENTRY:
            begin
                state_next = ST_IDLE;
                case (op_t'(op_reg))
                    OP_INSERT:
                    begin
                        mem_we    = ok_reg;
                        mem_wdata = updated;
                    end
                    OP_CLEAR:
                    begin
                        mem_we    = ok_reg;
                        mem_wdata = emptied;
                    end
                    OP_QUERY:
                    begin
                        res_feat_next = (ok_reg && cur.valid) ? cur.feat : '0;
                        res_dist_next = ok_reg ? cur.best : '0;
                        need_rev_next = ok_reg && (qi_reg != ti_reg)
                                     && ratio_pass(cur, ratio_reg)
                                     && (32'(cur.feat) < MAX_FEATURES);
                        mem_re        = 1'b1;
                        mem_raddr     = rev_addr;
                        state_next    = ST_REVERSE;
                    end
                    default: ;
                endcase
            end
            ST_REVERSE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_match_next = need_rev_reg && ratio_pass(cur, ratio_reg)
                                  && (cur.feat == qf_reg);
                    out_feat_next  = res_feat_reg;
                    out_dist_next  = res_dist_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            ratio_reg     <= RATIO_RESET;
            empty_reg     <= EMPTY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            ratio_reg     <= ratio_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        qi_reg        <= qi_next;
        ti_reg        <= ti_next;
        qf_reg        <= qf_next;
        tf_reg        <= tf_next;
        dist_reg      <= dist_next;
        ok_reg        <= ok_next;
        need_rev_reg  <= need_rev_next;
        res_feat_reg  <= res_feat_next;
        res_dist_reg  <= res_dist_next;
        out_match_reg <= out_match_next;
        out_feat_reg  <= out_feat_next;
        out_dist_reg  <= out_dist_next;
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.match_valid     = out_match_reg;
    assign result_out.matched_feature = out_feat_reg;
    assign result_out.match_distance  = out_dist_reg;

endmodule

// File: sim/ratio_cross_check_match_refiner_top_tb.sv
`timescale 1ns / 1ps

module ratio_cross_check_match_refiner_top_tb;
    import rccm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam int                   DRAIN_CYCLES = 8;
    localparam int                   TABLE_DEPTH = 1 << (2 * IMG_FW + FEAT_FW);

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [IMG_FW-1:0]  qi;
        logic [IMG_FW-1:0]  ti;
        logic [FEAT_FW-1:0] qf;
        logic [FEAT_FW-1:0] tf;
        logic [DIST_W-1:0]  distance;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [FEAT_FW-1:0] feature;
        logic [DIST_W-1:0]  distance;
    } match_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rccm_in_if  item_if ();
    rccm_out_if match_if ();

    ratio_cross_check_match_refiner_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (match_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    entry_t             best_two [TABLE_DEPTH];
    logic [RATIO_W-1:0] ratio_cfg;
    logic [DIST_W-1:0]  empty_cfg;
    match_t             expected_matches [$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 sink_hold = 0;
    bit                 tx_idle_on = 1'b1;
    bit                 rx_idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("ratio_cross_check_match_refiner_top_tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FEAT_FW-1:0] pick_feature();
        if ($urandom_range(0, 4) != 0)
            return FEAT_FW'($urandom_range(0, 15));
        return FEAT_FW'($urandom_range(0, 1023));
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && empty_cfg != 0)
            return DIST_W'($urandom_range(0, int'(empty_cfg) - 1));
        if (r < 8)
            return DIST_W'($urandom_range(0, 65535));
        return DIST_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [DIST_W-1:0] near_distance(input logic [DIST_W-1:0] d);
        int t;
        t = int'(d) + $urandom_range(0, int'(d) / 2 + 2);
        return (t > 65535) ? 16'hFFFF : t[DIST_W-1:0];
    endfunction

    function automatic item_t mk(input logic [OP_W-1:0] op, input logic [IMG_FW-1:0] qi,
                                 input logic [IMG_FW-1:0] ti, input logic [FEAT_FW-1:0] qf,
                                 input logic [FEAT_FW-1:0] tf, input logic [DIST_W-1:0] d);
        item_t it;
        it.op = op;
        it.qi = qi;
        it.ti = ti;
        it.qf = qf;
        it.tf = tf;
        it.distance = d;
        return it;
    endfunction

    function automatic bit ratio_passes(input entry_t e);
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = {16'd0, e.best} << 8;
        rhs = 32'(ratio_cfg) * 32'(e.second);
        return e.valid && (lhs < rhs);
    endfunction

    function automatic void refine_model(input item_t it);
        logic [15:0] idx;
        entry_t      e;
        entry_t      rev;
        match_t      m;
        idx = {it.qi, it.ti, it.qf};
        e = best_two[idx];
        case (it.op)
            OP_INSERT:
            begin
                if (it.distance < e.best)
                begin
                    e.second = e.best;
                    e.best = it.distance;
                    e.feat = it.tf;
                    e.valid = 1'b1;
                end
                else if (it.distance < e.second)
                begin
                    e.second = it.distance;
                end
                best_two[idx] = e;
            end
            OP_CLEAR:
            begin
                best_two[idx] = '{valid: 1'b0, feat: '0, best: empty_cfg, second: empty_cfg};
            end
            OP_QUERY:
            begin
                m.hit = (it.qi != it.ti) && ratio_passes(e);
                if (m.hit)
                begin
                    rev = best_two[{it.ti, it.qi, e.feat}];
                    m.hit = ratio_passes(rev) && (rev.feat == it.qf);
                end
                m.feature = e.valid ? e.feat : '0;
                m.distance = e.best;
                expected_matches = {expected_matches, m};
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid         <= 1'b1;
        item_if.op            <= it.op;
        item_if.query_image   <= it.qi;
        item_if.train_image   <= it.ti;
        item_if.query_feature <= it.qf;
        item_if.train_feature <= it.tf;
        item_if.distance      <= it.distance;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        refine_model(it);
        items_sent++;
    endtask

    // Inserts and clears leave nothing to wait for, so a drain wait is added for them.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RATIO)
            ratio_cfg = value[RATIO_W-1:0];
        else if (idx == CFG_EMPTY)
            empty_cfg = value[DIST_W-1:0];
    endtask

    // Optional clears, then a mutual pair with runners-up on both sides, then a query from one or both ends.
    task automatic send_match_scenario();
        logic [IMG_FW-1:0]  qi;
        logic [IMG_FW-1:0]  ti;
        logic [FEAT_FW-1:0] qf;
        logic [FEAT_FW-1:0] tf;
        logic [DIST_W-1:0]  d1;
        logic [DIST_W-1:0]  d3;
        qi = IMG_FW'($urandom_range(0, 7));
        ti = ($urandom_range(0, 7) == 0) ? qi : IMG_FW'($urandom_range(0, 7));
        qf = pick_feature();
        tf = pick_feature();
        if ($urandom_range(0, 1) == 0)
        begin
            send_item(mk(OP_CLEAR, qi, ti, qf, pick_feature(), pick_distance()));
            send_item(mk(OP_CLEAR, ti, qi, tf, pick_feature(), pick_distance()));
        end
        d1 = pick_distance();
        d3 = pick_distance();
        send_item(mk(OP_INSERT, qi, ti, qf, tf, d1));
        send_item(mk(OP_INSERT, qi, ti, qf, pick_feature(), near_distance(d1)));
        send_item(mk(OP_INSERT, ti, qi, tf, qf, d3));
        send_item(mk(OP_INSERT, ti, qi, tf, pick_feature(), near_distance(d3)));
        send_item(mk(OP_QUERY, qi, ti, qf, pick_feature(), pick_distance()));
        if ($urandom_range(0, 1) == 0)
            send_item(mk(OP_QUERY, ti, qi, tf, pick_feature(), pick_distance()));
    endtask

    task automatic send_noise_item();
        send_item(mk(OP_W'($urandom_range(0, 3)), IMG_FW'($urandom_range(0, 7)),
                     IMG_FW'($urandom_range(0, 7)), pick_feature(), pick_feature(),
                     pick_distance()));
    endtask

    task automatic test_directed();
        send_item(mk(OP_QUERY, 0, 1, 0, 0, 0));
        send_item(mk(OP_INSERT, 0, 1, 3, 7, 160));
        send_item(mk(OP_INSERT, 0, 1, 3, 8, 400));
        send_item(mk(OP_INSERT, 1, 0, 7, 3, 200));
        send_item(mk(OP_INSERT, 1, 0, 7, 11, 480));
        send_item(mk(OP_QUERY, 0, 1, 3, 0, 0));
        send_item(mk(OP_QUERY, 1, 0, 7, 0, 0));
        send_item(mk(OP_INSERT, 0, 1, 4, 7, 100));
        send_item(mk(OP_QUERY, 0, 1, 4, 0, 0));
        send_item(mk(OP_INSERT, 0, 2, 6, 20, 50));
        send_item(mk(OP_QUERY, 0, 2, 6, 0, 0));
        send_item(mk(OP_INSERT, 2, 2, 5, 9, 100));
        send_item(mk(OP_QUERY, 2, 2, 5, 0, 0));
        send_item(mk(OP_INSERT, 3, 4, 1, 2, 0));
        send_item(mk(OP_INSERT, 3, 4, 1, 5, 0));
        send_item(mk(OP_QUERY, 3, 4, 1, 0, 0));
        send_item(mk(OP_INSERT, 7, 6, 1023, 1023, 16'hFFFF));
        send_item(mk(OP_INSERT, 7, 6, 1023, 1023, 15999));
        send_item(mk(OP_INSERT, 6, 7, 1023, 1023, 1));
        send_item(mk(OP_QUERY, 7, 6, 1023, 1023, 16'hFFFF));
        send_item(mk(OP_CLEAR, 0, 1, 3, 0, 0));
        send_item(mk(OP_QUERY, 0, 1, 3, 0, 0));
        send_item(mk(OP_UNUSED, 1, 0, 7, 1023, 16'hFFFF));
        send_item(mk(OP_QUERY, 1, 0, 7, 0, 0));
        wait_idle();
    endtask

    task automatic test_config_extremes();
        int phase;
        int stop_at;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(CFG_RATIO, 16'd0);
                1: write_reg(CFG_RATIO, 16'd1023);
                2:
                begin
                    write_reg(CFG_RATIO, 16'd128);
                    write_reg(CFG_EMPTY, 16'd0);
                end
                3:
                begin
                    write_reg(CFG_RATIO, 16'd256);
                    write_reg(CFG_EMPTY, 16'hFFFF);
                end
                4:
                begin
                    write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_reg(CFG_EMPTY, 16'd1);
                end
                default:
                begin
                    write_reg(CFG_RATIO, CFG_DATA_W'(RATIO_RESET));
                    write_reg(CFG_EMPTY, EMPTY_RESET);
                end
            endcase
            stop_at = items_sent + 60;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_match_scenario();
                else
                    send_noise_item();
            end
            wait_idle();
        end
    endtask

    task automatic test_back_pressure();
        int n;
        tx_idle_on = 1'b0;
        @(negedge clk);
        sink_hold = 600;
        @(posedge clk);
        for (n = 0; n < 60; n++)
            send_item(mk(OP_QUERY, IMG_FW'($urandom_range(0, 7)), IMG_FW'($urandom_range(0, 7)),
                         FEAT_FW'($urandom_range(0, 15)), 0, 0));
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random();
        int stop_at;
        int next_cfg;
        int next_mode;
        stop_at = items_sent + 1100;
        next_cfg = items_sent + 200;
        next_mode = items_sent + 100;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_cfg)
            begin
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_RATIO, CFG_DATA_W'($urandom_range(0, 1023)));
                else
                    write_reg(CFG_RATIO, CFG_DATA_W'($urandom_range(200, 600)));
                if ($urandom_range(0, 4) == 0)
                    write_reg(CFG_EMPTY, CFG_DATA_W'($urandom_range(0, 65535)));
                else
                    write_reg(CFG_EMPTY, CFG_DATA_W'($urandom_range(4000, 65535)));
                next_cfg += 200;
            end
            if (items_sent >= next_mode)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                next_mode += 100;
            end
            if ($urandom_range(0, 9) < 7)
                send_match_scenario();
            else
                send_noise_item();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    initial
    begin : result_sink
        match_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                match_if.ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                match_if.ready <= 1'b0;
                sink_hold = pick_gap() - 1;
            end
            else
            begin
                match_if.ready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input bit unexpected, input match_t want, input match_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (unexpected)
                $display("mismatch: unexpected result valid=%0b feature=%0d distance=%0d",
                         got.hit, got.feature, got.distance);
            else
            begin
                $display("mismatch: expected valid=%0b feature=%0d distance=%0d",
                         want.hit, want.feature, want.distance);
                $display("          actual   valid=%0b feature=%0d distance=%0d",
                         got.hit, got.feature, got.distance);
            end
        end
    endtask

    initial
    begin : result_check
        match_t got;
        match_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && match_if.valid === 1'b1 && match_if.ready === 1'b1)
            begin
                got.hit = match_if.match_valid;
                got.feature = match_if.matched_feature;
                got.distance = match_if.match_distance;
                if (expected_matches.size() == 0)
                begin
                    note_mismatch(1'b1, '0, got);
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (got.hit !== want.hit || got.feature !== want.feature
                        || got.distance !== want.distance)
                        note_mismatch(1'b0, want, got);
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        item_if.valid         <= 1'b0;
        item_if.op            <= '0;
        item_if.query_image   <= '0;
        item_if.train_image   <= '0;
        item_if.query_feature <= '0;
        item_if.train_feature <= '0;
        item_if.distance      <= '0;
        ratio_cfg = RATIO_RESET;
        empty_cfg = EMPTY_RESET;
        for (i = 0; i < TABLE_DEPTH; i++)
            best_two[i] = '{valid: 1'b0, feat: '0, best: EMPTY_RESET, second: EMPTY_RESET};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_back_pressure();
        test_random();

        wait_idle();
        if (mismatches == 0)
            $display("ratio_cross_check_match_refiner_top_tb OK");
        else
            $display("ratio_cross_check_match_refiner_top_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hdl/rccm_pkg.sv
hdl/rccm_if.sv
hdl/rccm_table_mem.sv
hdl/ratio_cross_check_match_refiner_top.sv
sim/ratio_cross_check_match_refiner_top_tb.sv
